### hw/rtl/tmu_pkg.sv
// shared constants for the triangle measure unit
package tmu_pkg;

  localparam int SIDE_BITS_DEF   = 12;
  localparam int RADIUS_FRAC_DEF = 8;

  localparam int IN_W    = 12;
  localparam int AREA_W  = 25;
  localparam int OUTER_W = 32;
  localparam int INNER_W = 20;
  localparam int KIND_W  = 2;

  localparam logic [KIND_W-1:0] KIND_RIGHT  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ACUTE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_OBTUSE = 2'd2;

endpackage

### hw/rtl/tmu_front.sv
// front end: sorts the sides and checks the triangle inequality
module tmu_front
  import tmu_pkg::*;
#(
  parameter int SIDE_BITS = SIDE_BITS_DEF
) (
  input  logic                   start,
  input  logic                   busy,
  input  logic [SIDE_BITS-1:0]   a,
  input  logic [SIDE_BITS-1:0]   b,
  input  logic [SIDE_BITS-1:0]   c,
  output logic                   push,
  output logic [3*SIDE_BITS:0]   item
);

  logic [SIDE_BITS-1:0] h0, m0, h1, l1, m2, l2;
  logic [SIDE_BITS:0]   sum_ml;
  logic                 bad;

  always_comb begin
    h0 = (b > a) ? b : a;
    m0 = (b > a) ? a : b;
    h1 = (c > h0) ? c : h0;
    l1 = (c > h0) ? h0 : c;
    m2 = (l1 > m0) ? l1 : m0;
    l2 = (l1 > m0) ? m0 : l1;
    sum_ml = {1'b0, m2} + {1'b0, l2};
    bad = (l2 == '0) || ({1'b0, h1} >= sum_ml);
  end

  assign push = start && !busy;
  assign item = {bad, h1, m2, l2};

endmodule

### hw/rtl/tmu_fifo.sv
// two-entry queue between front and back
module tmu_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  output logic         out_valid,
  output logic [W-1:0] dout
);

  logic [W-1:0] mem [0:1];
  logic         wr_ptr, rd_ptr;
  logic [1:0]   count;

  assign out_valid = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign dout      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  // entries leave every cycle there is one
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (out_valid) rd_ptr <= ~rd_ptr;
      if (push && !out_valid) count <= count + 2'd1;
      else if (!push && out_valid) count <= count - 2'd1;
    end
  end

endmodule

### hw/rtl/tmu_sqrt_pipe.sv
// pipelined integer square root, one root bit per stage
module tmu_sqrt_pipe #(
  parameter int AW = 8,
  parameter int TW = 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [2*AW-1:0] rad_in,
  input  logic [TW-1:0]   tag_in,
  output logic            out_valid,
  output logic [AW-1:0]   root_out,
  output logic [TW-1:0]   tag_out
);

  localparam int RW  = 2 * AW;
  localparam int RMW = AW + 2;

  logic            v    [0:AW];
  logic [RW-1:0]   rad  [0:AW];
  logic [RMW-1:0]  rem  [0:AW];
  logic [AW-1:0]   root [0:AW];
  logic [TW-1:0]   tag  [0:AW];

  assign v[0]    = in_valid;
  assign rad[0]  = rad_in;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign tag[0]  = tag_in;

  for (genvar k = 0; k < AW; k++) begin : g_stage
    logic [RMW+1:0] cur, trial, diff;
    logic           ge;

    always_comb begin
      cur   = {rem[k], rad[k][RW-1-2*k -: 2]};
      trial = {2'b00, root[k], 2'b01};
      diff  = cur - trial;
      ge    = (cur >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      rad[k+1]  <= rad[k];
      tag[k+1]  <= tag[k];
      rem[k+1]  <= ge ? diff[RMW-1:0] : cur[RMW-1:0];
      root[k+1] <= {root[k][AW-2:0], ge};
    end
  end

  assign out_valid = v[AW];
  assign root_out  = root[AW];
  assign tag_out   = tag[AW];

endmodule

### hw/rtl/tmu_div_pipe.sv
// pipelined restoring divider, one quotient bit per stage
module tmu_div_pipe #(
  parameter int NW = 8,
  parameter int DW = 4,
  parameter int TW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  input  logic [TW-1:0] tag_in,
  output logic          out_valid,
  output logic [NW-1:0] quotient,
  output logic [TW-1:0] tag_out
);

  logic          v   [0:NW];
  logic [NW-1:0] dvd [0:NW];
  logic [DW-1:0] dsr [0:NW];
  logic [DW-1:0] rem [0:NW];
  logic [NW-1:0] q   [0:NW];
  logic [TW-1:0] tag [0:NW];

  assign v[0]   = in_valid;
  assign dvd[0] = dividend;
  assign dsr[0] = divisor;
  assign rem[0] = '0;
  assign q[0]   = '0;
  assign tag[0] = tag_in;

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [DW:0] cur, diff;
    logic        ge;

    always_comb begin
      cur  = {rem[k], dvd[k][NW-1-k]};
      ge   = (cur >= {1'b0, dsr[k]});
      diff = cur - {1'b0, dsr[k]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      dvd[k+1] <= dvd[k];
      dsr[k+1] <= dsr[k];
      tag[k+1] <= tag[k];
      rem[k+1] <= ge ? diff[DW-1:0] : cur[DW-1:0];
      q[k+1]   <= {q[k][NW-2:0], ge};
    end
  end

  assign out_valid = v[NW];
  assign quotient  = q[NW];
  assign tag_out   = tag[NW];

endmodule

### hw/rtl/tmu_back.sv
// back end: products, square root, divisions and output saturation
module tmu_back
  import tmu_pkg::*;
#(
  parameter int SIDE_BITS        = SIDE_BITS_DEF,
  parameter int RADIUS_FRAC_BITS = RADIUS_FRAC_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [3*SIDE_BITS:0] item,
  output logic                 done,
  output logic [AREA_W-1:0]    area_x4,
  output logic [OUTER_W-1:0]   outer_radius_q8,
  output logic [INNER_W-1:0]   inner_radius_q8,
  output logic [KIND_W-1:0]    angle_kind,
  output logic                 not_triangle,
  output logic                 radius_saturated
);

  localparam int S   = SIDE_BITS;
  localparam int F   = RADIUS_FRAC_BITS;
  localparam int PW  = 4 * S + 5;
  localparam int AW  = 2 * S + 3;
  localparam int NW  = 3 * S + F;
  localparam int IDW = S + 3;
  localparam int STW = 1 + KIND_W + 3 * S + S + 2;
  localparam int OTW = 1 + KIND_W;
  localparam int AXW = (AW + F > AREA_W) ? AW + F : AREA_W;
  localparam int OXW = (NW > OUTER_W) ? NW : OUTER_W;
  localparam int IXW = (NW > INNER_W) ? NW : INNER_W;

  logic [S-1:0] hi, mid, lo;
  logic         nt_in;
  assign {nt_in, hi, mid, lo} = item;

  // stage a: sums, differences, small products
  logic           va, nta;
  logic [S+1:0]   perim_a;
  logic [S:0]     d1_a, d2_a, d3_a;
  logic [2*S-1:0] ab_a, sqh_a;
  logic [2*S:0]   sqs_a;
  logic [S-1:0]   lo_a;

  always_ff @(posedge clk) begin
    if (rst) va <= 1'b0;
    else     va <= in_valid;
  end

  always_ff @(posedge clk) begin
    nta     <= nt_in;
    perim_a <= (S+2)'(hi) + (S+2)'(mid) + (S+2)'(lo);
    d1_a    <= (S+1)'(mid) + (S+1)'(lo) - (S+1)'(hi);
    d2_a    <= (S+1)'(hi) + (S+1)'(lo) - (S+1)'(mid);
    d3_a    <= (S+1)'(hi) + (S+1)'(mid) - (S+1)'(lo);
    ab_a    <= (2*S)'(hi) * (2*S)'(mid);
    sqh_a   <= (2*S)'(hi) * (2*S)'(hi);
    sqs_a   <= (2*S+1)'((2*S)'(mid) * (2*S)'(mid)) + (2*S+1)'((2*S)'(lo) * (2*S)'(lo));
    lo_a    <= lo;
  end

  // stage b: partial products and angle kind
  logic              vb, ntb;
  logic [2*S+2:0]    m1_b;
  logic [2*S+1:0]    m2_b;
  logic [3*S-1:0]    abc_b;
  logic [S+1:0]      perim_b;
  logic [KIND_W-1:0] kind_b;

  always_ff @(posedge clk) begin
    if (rst) vb <= 1'b0;
    else     vb <= va;
  end

  always_ff @(posedge clk) begin
    ntb     <= nta;
    m1_b    <= (2*S+3)'(perim_a) * (2*S+3)'(d1_a);
    m2_b    <= (2*S+2)'(d2_a) * (2*S+2)'(d3_a);
    abc_b   <= (3*S)'(ab_a) * (3*S)'(lo_a);
    perim_b <= perim_a;
    if (sqs_a == (2*S+1)'(sqh_a))     kind_b <= KIND_RIGHT;
    else if (sqs_a > (2*S+1)'(sqh_a)) kind_b <= KIND_ACUTE;
    else                              kind_b <= KIND_OBTUSE;
  end

  // stage c: sixteen times squared area
  logic          vc;
  logic [PW-1:0] p_c;
  logic [STW-1:0] tag_c;

  always_ff @(posedge clk) begin
    if (rst) vc <= 1'b0;
    else     vc <= vb;
  end

  always_ff @(posedge clk) begin
    p_c   <= PW'(m1_b) * PW'(m2_b);
    tag_c <= {ntb, kind_b, abc_b, perim_b};
  end

  logic           vs;
  logic [AW-1:0]  area_s;
  logic [STW-1:0] tag_s;

  tmu_sqrt_pipe #(.AW(AW), .TW(STW)) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vc),
    .rad_in    ((2*AW)'(p_c)),
    .tag_in    (tag_c),
    .out_valid (vs),
    .root_out  (area_s),
    .tag_out   (tag_s)
  );

  logic              nt_s;
  logic [KIND_W-1:0] kind_s;
  logic [3*S-1:0]    abc_s;
  logic [S+1:0]      perim_s;
  assign {nt_s, kind_s, abc_s, perim_s} = tag_s;

  logic          vd;
  logic [NW-1:0] outer_q, inner_q;
  logic [OTW-1:0] otag;
  logic [AW-1:0]  area_d;

  tmu_div_pipe #(.NW(NW), .DW(AW), .TW(OTW)) u_div_outer (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vs),
    .dividend  (NW'(abc_s) << F),
    .divisor   (area_s),
    .tag_in    ({nt_s, kind_s}),
    .out_valid (vd),
    .quotient  (outer_q),
    .tag_out   (otag)
  );

  // runs in step with the outer divider, carries the area along
  tmu_div_pipe #(.NW(NW), .DW(IDW), .TW(AW)) u_div_inner (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vs),
    .dividend  (NW'(area_s) << F),
    .divisor   ({perim_s, 1'b0}),
    .tag_in    (area_s),
    .out_valid (),
    .quotient  (inner_q),
    .tag_out   (area_d)
  );

  logic [AXW-1:0] area_x;
  logic [OXW-1:0] outer_x;
  logic [IXW-1:0] inner_x;
  assign area_x  = AXW'(area_d);
  assign outer_x = OXW'(outer_q);
  assign inner_x = IXW'(inner_q);

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= vd;
  end

  always_ff @(posedge clk) begin
    if (otag[OTW-1]) begin
      area_x4          <= '0;
      outer_radius_q8  <= '0;
      inner_radius_q8  <= '0;
      angle_kind       <= KIND_RIGHT;
      not_triangle     <= 1'b1;
      radius_saturated <= 1'b0;
    end else begin
      area_x4 <= (area_x > AXW'({AREA_W{1'b1}})) ? {AREA_W{1'b1}} : area_x[AREA_W-1:0];
      if (outer_x > OXW'({OUTER_W{1'b1}})) begin
        outer_radius_q8  <= {OUTER_W{1'b1}};
        radius_saturated <= 1'b1;
      end else begin
        outer_radius_q8  <= outer_x[OUTER_W-1:0];
        radius_saturated <= 1'b0;
      end
      inner_radius_q8 <= (inner_x > IXW'({INNER_W{1'b1}})) ? {INNER_W{1'b1}}
                                                           : inner_x[INNER_W-1:0];
      angle_kind   <= otag[KIND_W-1:0];
      not_triangle <= 1'b0;
    end
  end

endmodule

### hw/rtl/triangle_measure_unit.sv
// top level of the triangle measure unit
//
// usage: drive side_a, side_b, side_c and raise start; a beat is taken at a
// clock edge with start high and busy low. busy rises only if the two-entry
// queue behind the front end fills, which with one beat a cycle never happens,
// so a new triangle can be taken every cycle.
// each beat gives one result beat: done is high for exactly one cycle with
// area_x4, outer_radius_q8, inner_radius_q8, angle_kind, not_triangle and
// radius_saturated valid in that cycle. results come out in input order.
// done follows the accepting edge through the queue, three product stages,
// one square root bit per stage, one quotient bit per divider stage and the
// output register; the queue is written at the accepting edge and read by the
// first product stage at the next one.
// throughput is one triangle per cycle.
// the receiver cannot stall, so nothing holds results back.
// synchronous reset rst empties the queue and clears every pipeline valid;
// no result beat is given for items in flight at reset.
module triangle_measure_unit
  import tmu_pkg::*;
#(
  parameter int SIDE_BITS        = SIDE_BITS_DEF,
  parameter int RADIUS_FRAC_BITS = RADIUS_FRAC_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [IN_W-1:0]    side_a,
  input  logic [IN_W-1:0]    side_b,
  input  logic [IN_W-1:0]    side_c,
  output logic               done,
  output logic [AREA_W-1:0]  area_x4,
  output logic [OUTER_W-1:0] outer_radius_q8,
  output logic [INNER_W-1:0] inner_radius_q8,
  output logic [KIND_W-1:0]  angle_kind,
  output logic               not_triangle,
  output logic               radius_saturated
);

  localparam int S   = SIDE_BITS;
  localparam int XW  = (IN_W > S) ? IN_W : S;
  localparam int ITW = 3 * S + 1;

  logic [XW-1:0]  xa, xb, xc;
  logic           push, q_valid;
  logic [ITW-1:0] f_item, q_item;

  assign xa = XW'(side_a);
  assign xb = XW'(side_b);
  assign xc = XW'(side_c);

  tmu_front #(.SIDE_BITS(S)) u_front (
    .start (start),
    .busy  (busy),
    .a     (xa[S-1:0]),
    .b     (xb[S-1:0]),
    .c     (xc[S-1:0]),
    .push  (push),
    .item  (f_item)
  );

  tmu_fifo #(.W(ITW)) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .din       (f_item),
    .full      (busy),
    .out_valid (q_valid),
    .dout      (q_item)
  );

  tmu_back #(.SIDE_BITS(S), .RADIUS_FRAC_BITS(RADIUS_FRAC_BITS)) u_back (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (q_valid),
    .item             (q_item),
    .done             (done),
    .area_x4          (area_x4),
    .outer_radius_q8  (outer_radius_q8),
    .inner_radius_q8  (inner_radius_q8),
    .angle_kind       (angle_kind),
    .not_triangle     (not_triangle),
    .radius_saturated (radius_saturated)
  );

endmodule

### tb/tb_top.sv
// testbench for the triangle measure unit: random and directed triangles checked against a predictor
`timescale 1ns / 100ps

typedef struct {
  logic [24:0] area;
  logic [31:0] outer;
  logic [19:0] inner;
  logic [1:0]  kind;
  logic        bad;
  logic        sat;
} measure_t;

class tri_scoreboard;
  measure_t pending[$];
  int       errors;

  function logic [63:0] isqrt(logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n   = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function void note_sides(logic [11:0] sa, logic [11:0] sb, logic [11:0] sc);
    measure_t    m;
    logic [63:0] a, b, c, hi, mid, lo, t, perim, prod, area, outer, inner, lhs, rhs;
    a = sa; b = sb; c = sc;
    m = '{default: '0};
    if (a == 0 || b == 0 || c == 0 || a >= b + c || b >= a + c || c >= a + b) begin
      m.bad = 1'b1;
      pending.push_back(m);
      return;
    end
    perim = a + b + c;
    prod  = perim * (b + c - a) * (a + c - b) * (a + b - c);
    area  = isqrt(prod);
    if (area == 0) begin
      outer = 64'hFFFF_FFFF;
      m.sat = 1'b1;
    end else begin
      outer = ((a * b * c) << 8) / area;
      if (outer > 64'hFFFF_FFFF) begin
        outer = 64'hFFFF_FFFF;
        m.sat = 1'b1;
      end
    end
    inner = (area << 8) / (2 * perim);
    if (inner > 64'hF_FFFF) inner = 64'hF_FFFF;
    hi = a; mid = b; lo = c;
    if (mid > hi) begin t = hi; hi = mid; mid = t; end
    if (lo > hi) begin t = hi; hi = lo; lo = t; end
    if (lo > mid) begin t = mid; mid = lo; lo = t; end
    lhs = mid * mid + lo * lo;
    rhs = hi * hi;
    if (lhs == rhs) m.kind = tmu_pkg::KIND_RIGHT;
    else if (lhs > rhs) m.kind = tmu_pkg::KIND_ACUTE;
    else m.kind = tmu_pkg::KIND_OBTUSE;
    m.area  = (area > 64'h1FF_FFFF) ? 25'h1FF_FFFF : area[24:0];
    m.outer = outer[31:0];
    m.inner = inner[19:0];
    pending.push_back(m);
  endfunction

  task report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    errors++;
  endtask

  task check_measure(measure_t got);
    measure_t w;
    if (pending.size() == 0) begin
      $display("mismatch: result beat with nothing expected");
      errors++;
      return;
    end
    w = pending.pop_front();
    if (got.area !== w.area) report("area_x4", 64'(got.area), 64'(w.area));
    if (got.outer !== w.outer) report("outer_radius_q8", 64'(got.outer), 64'(w.outer));
    if (got.inner !== w.inner) report("inner_radius_q8", 64'(got.inner), 64'(w.inner));
    if (got.kind !== w.kind) report("angle_kind", 64'(got.kind), 64'(w.kind));
    if (got.bad !== w.bad) report("not_triangle", 64'(got.bad), 64'(w.bad));
    if (got.sat !== w.sat) report("radius_saturated", 64'(got.sat), 64'(w.sat));
  endtask
endclass

module tb_top;
  import tmu_pkg::*;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [IN_W-1:0]    side_a = '0, side_b = '0, side_c = '0;
  logic               done;
  logic [AREA_W-1:0]  area_x4;
  logic [OUTER_W-1:0] outer_radius_q8;
  logic [INNER_W-1:0] inner_radius_q8;
  logic [KIND_W-1:0]  angle_kind;
  logic               not_triangle;
  logic               radius_saturated;

  tri_scoreboard measures = new();
  int            quiet_cycles = 0;
  bit            calm = 1'b0;

  localparam int QUIET_LIMIT = 2000;

  triangle_measure_unit dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // sample beats at the rising edge
  always @(posedge clk) begin
    measure_t got;
    if (!rst && done) begin
      got.area  = area_x4;
      got.outer = outer_radius_q8;
      got.inner = inner_radius_q8;
      got.kind  = angle_kind;
      got.bad   = not_triangle;
      got.sat   = radius_saturated;
      measures.check_measure(got);
    end
    if (!rst && start && !busy) measures.note_sides(side_a, side_b, side_c);
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // busy only changes at rising edges, so its value at the falling edge
  // is the one the next rising edge sees
  task send_sides(logic [11:0] a, logic [11:0] b, logic [11:0] c);
    if (!calm && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    start  <= 1'b1;
    side_a <= a;
    side_b <= b;
    side_c <= c;
    while (busy) @(negedge clk);
    @(negedge clk);
  endtask

  task send_random;
    logic [11:0] a, b, c, m, n;
    int          pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      a = 12'($urandom_range(1, 4095));
      b = 12'($urandom_range(1, 4095));
      c = 12'($urandom_range((a > b ? a - b : b - a) + 1,
                             (a + b - 1 > 4095) ? 4095 : a + b - 1));
    end else if (pick == 6) begin
      // pythagorean triples from euclid's formula
      m = 12'($urandom_range(2, 45));
      n = 12'($urandom_range(1, m - 1));
      a = m * m - n * n; b = 12'(2 * m * n); c = m * m + n * n;
    end else if (pick == 7) begin
      // thin triangles stress the circumradius
      a = 12'($urandom_range(1, 2047));
      b = 12'($urandom_range(1, 2047));
      c = a + b - 12'd1;
    end else begin
      a = 12'($urandom); b = 12'($urandom); c = 12'($urandom);
    end
    case ($urandom_range(0, 2))
      0: send_sides(a, b, c);
      1: send_sides(c, a, b);
      default: send_sides(b, c, a);
    endcase
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    send_sides(12'd0, 12'd0, 12'd0);
    send_sides(12'd0, 12'd5, 12'd5);
    send_sides(12'd1, 12'd1, 12'd1);
    send_sides(12'd4095, 12'd4095, 12'd4095);
    send_sides(12'd3, 12'd4, 12'd5);
    send_sides(12'd5, 12'd3, 12'd4);
    send_sides(12'd4, 12'd5, 12'd3);
    send_sides(12'd1, 12'd2, 12'd3);
    send_sides(12'd4095, 12'd1, 12'd4095);
    send_sides(12'd4095, 12'd4094, 12'd1);
    send_sides(12'd2048, 12'd2047, 12'd4094);
    send_sides(12'd4095, 12'd4095, 12'd1);
    send_sides(12'd2, 12'd3, 12'd4);
    send_sides(12'd4095, 12'd4095, 12'd4094);
    send_sides(12'd1, 12'd4095, 12'd4095);
    send_sides(12'd2730, 12'd1365, 12'd4094);
    send_sides(12'd2, 12'd2, 12'd3);
    send_sides(12'd2457, 12'd3276, 12'd4095);
    send_sides(12'd4095, 12'd0, 12'd4095);
    send_sides(12'd4095, 12'd4095, 12'd0);
    for (int i = 0; i < 850; i++) begin
      if (i == 700) calm = 1'b1;
      send_random();
    end
    start <= 1'b0;
    while (measures.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (measures.errors == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end
endmodule
